// ----- rtl/core/y86_stack_op_unit_defines.svh -----
// assertion macros shared by the stack operation unit
`ifndef Y86_STACK_OP_UNIT_DEFINES_SVH
`define Y86_STACK_OP_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define Y86SO_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define Y86SO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/y86so_pkg.sv -----
// shared constants, codes and types of the stack operation unit
`default_nettype none

package y86so_pkg;

   // memory geometry: eight byte-wide banks, one byte lane each
   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int BANKS     = 8;
   localparam int ROWS      = MEM_BYTES / BANKS;
   localparam int ROW_AW    = MEM_AW - 3;

   // register file
   localparam int REG_COUNT = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam logic [REG_AW-1:0] RSP_INDEX = REG_AW'(4);

   // field widths
   localparam int WORD_W  = 64;
   localparam int LOAD_AW = 12;
   localparam int PSIZE_W = 13;
   localparam int LIM_W   = (MEM_AW + 1 > PSIZE_W) ? MEM_AW + 1 : PSIZE_W;
   localparam logic [PSIZE_W-1:0] PSIZE_RESET = PSIZE_W'(4096);

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_PSIZE = 1'b0;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // function codes
   localparam logic [1:0] FUNC_EXEC   = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_SETREG = 2'd2;

   // instruction codes
   localparam logic [3:0] ICODE_CALL  = 4'd8;
   localparam logic [3:0] ICODE_RET   = 4'd9;
   localparam logic [3:0] ICODE_PUSHQ = 4'd10;
   localparam logic [3:0] ICODE_POPQ  = 4'd11;

   typedef enum logic [2:0] {
      KIND_CALL,
      KIND_RET,
      KIND_PUSH,
      KIND_POP,
      KIND_LOAD,
      KIND_SETREG,
      KIND_FAIL
   } kind_type;

   // decoded item; operand is the call target or the load/set value
   typedef struct packed {
      kind_type                kind;
      logic [REG_AW-1:0]       reg_a;
      logic [WORD_W-1:0]       operand;
      logic [WORD_W-1:0]       val_p;
      logic [LOAD_AW-1:0]      load_addr;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/core/y86so_bank.sv -----
// one byte-wide memory bank with registered read data
`default_nettype none

module y86so_bank (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic                         we,
   input  wire logic [y86so_pkg::ROW_AW-1:0] addr,
   input  wire logic [7:0]                   wdata,
   output logic [7:0]                        rdata
);
   import y86so_pkg::*;

   logic [7:0] mem_ff [ROWS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/y86so_front.sv -----
// front end: takes request beats and classifies them into queue items
`default_nettype none

module y86so_front (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    func,
   input  wire logic [3:0]                    icode,
   input  wire logic [3:0]                    reg_a,
   input  wire logic [63:0]                   val_c,
   input  wire logic [63:0]                   val_p,
   input  wire logic [y86so_pkg::LOAD_AW-1:0] load_addr,
   input  wire logic [63:0]                   load_value,
   input  wire logic                          q_ready,
   output logic                               q_push,
   output y86so_pkg::item_type                q_item
);
   import y86so_pkg::*;

   logic load_in_range;

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   // byte loads beyond the memory fail up front
   assign load_in_range = ({{(WORD_W-LOAD_AW){1'b0}}, load_addr} < WORD_W'(MEM_BYTES));

   always_comb begin
      q_item.kind      = KIND_FAIL;
      q_item.reg_a     = REG_AW'(reg_a);
      q_item.operand   = load_value;
      q_item.val_p     = val_p;
      q_item.load_addr = load_addr;
      unique case (func)
         FUNC_EXEC: begin
            unique case (icode)
               ICODE_CALL: begin
                  q_item.kind    = KIND_CALL;
                  q_item.operand = val_c;
               end
               ICODE_RET:   q_item.kind = KIND_RET;
               ICODE_PUSHQ: q_item.kind = KIND_PUSH;
               ICODE_POPQ:  q_item.kind = KIND_POP;
               default:     q_item.kind = KIND_FAIL;
            endcase
         end
         FUNC_LOAD:   q_item.kind = load_in_range ? KIND_LOAD : KIND_FAIL;
         FUNC_SETREG: q_item.kind = KIND_SETREG;
         default:     q_item.kind = KIND_FAIL;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/y86so_queue.sv -----
// short queue of decoded items between front and back
`default_nettype none

module y86so_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_push,
   input  y86so_pkg::item_type      in_item,
   output logic                     in_ready,
   output logic                     out_valid,
   output y86so_pkg::item_type      out_item,
   input  wire logic                out_pop
);
   import y86so_pkg::*;

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] step_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign in_ready  = (count_ff != QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = out_pop ? step_ptr(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = in_push ? step_ptr(wr_ptr_ff) : wr_ptr_ff;
      case ({in_push, out_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/y86so_back.sv -----
// back end: issues memory access, holds result stage, commits state
`default_nettype none

module y86so_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [y86so_pkg::PSIZE_W-1:0] program_size,
   input  wire logic                          q_valid,
   input  y86so_pkg::item_type                q_item,
   output logic                               q_pop,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output logic                               res_ok,
   output logic [63:0]                        res_next_pc,
   output logic [63:0]                        res_stack_ptr,
   output logic [63:0]                        res_data_moved
);
   import y86so_pkg::*;

   // architectural state
   logic [WORD_W-1:0] rf_ff [REG_COUNT];
   logic [WORD_W-1:0] pc_ff;

   // result stage
   logic              s2_valid_ff;
   logic              s2_ok_ff, s2_ok_in;
   logic [WORD_W-1:0] s2_rsp_ff, s2_rsp_in;
   logic [WORD_W-1:0] s2_pc_ff, s2_pc_in;
   logic              s2_pc_mem_ff, s2_pc_mem_in;
   logic [WORD_W-1:0] s2_moved_ff, s2_moved_in;
   logic              s2_moved_mem_ff, s2_moved_mem_in;
   logic              s2_wr_en_ff, s2_wr_en_in;
   logic [REG_AW-1:0] s2_wr_idx_ff, s2_wr_idx_in;
   logic [WORD_W-1:0] s2_wr_val_ff, s2_wr_val_in;
   logic              s2_wr_mem_ff, s2_wr_mem_in;
   logic [2:0]        s2_off_ff, s2_off_in;

   // bank ports
   logic              bank_en    [BANKS];
   logic              bank_we    [BANKS];
   logic [ROW_AW-1:0] bank_addr  [BANKS];
   logic [7:0]        bank_wdata [BANKS];
   logic [7:0]        bank_rdata [BANKS];

   logic              issue, commit;
   logic [WORD_W-1:0] mem_quad, wb_val, final_rsp, final_pc;
   logic [WORD_W-1:0] rsp_view, pc_view, ra_view;
   logic [WORD_W-1:0] down_addr, up_addr, q_addr, wquad;
   logic [LIM_W-1:0]  lim, lim_psize, lim_mem;
   logic              quad_fine;
   logic              mem_wr_quad, mem_rd_quad, mem_wr_byte;
   logic [MEM_AW-1:0] ld_addr;
   logic [ROW_AW-1:0] q_row, q_row_next;
   logic [2:0]        byte_idx;

   function automatic logic quad_ok(input logic [WORD_W-1:0] a, input logic [LIM_W-1:0] l);
      logic high_zero;
      high_zero = (a[WORD_W-1:LIM_W] == '0);
      return (l >= LIM_W'(8)) && high_zero && (a[LIM_W-1:0] <= l - LIM_W'(8));
   endfunction

   assign issue  = q_valid && (!s2_valid_ff || res_ready);
   assign commit = s2_valid_ff && res_ready;
   assign q_pop  = issue;

   // reassemble the quad word from the rotated byte lanes
   always_comb begin
      for (int i = 0; i < BANKS; i++) begin
         mem_quad[8*i +: 8] = bank_rdata[3'(s2_off_ff + 3'(i))];
      end
   end

   assign wb_val    = s2_wr_mem_ff ? mem_quad : s2_wr_val_ff;
   assign final_rsp = (s2_wr_en_ff && (s2_wr_idx_ff == RSP_INDEX)) ? wb_val : s2_rsp_ff;
   assign final_pc  = s2_pc_mem_ff ? mem_quad : s2_pc_ff;

   assign res_valid      = s2_valid_ff;
   assign res_ok         = s2_ok_ff;
   assign res_next_pc    = final_pc;
   assign res_stack_ptr  = final_rsp;
   assign res_data_moved = s2_moved_mem_ff ? mem_quad : s2_moved_ff;

   // state as seen after the item in the result stage commits
   always_comb begin
      rsp_view = s2_valid_ff ? final_rsp : rf_ff[RSP_INDEX];
      pc_view  = s2_valid_ff ? final_pc : pc_ff;
      if (s2_valid_ff && s2_wr_en_ff && (s2_wr_idx_ff == q_item.reg_a)) begin
         ra_view = wb_val;
      end else if (s2_valid_ff && (q_item.reg_a == RSP_INDEX)) begin
         ra_view = s2_rsp_ff;
      end else begin
         ra_view = rf_ff[q_item.reg_a];
      end
   end

   // quad access window
   always_comb begin
      lim_psize = LIM_W'(program_size);
      lim_mem   = LIM_W'(MEM_BYTES);
      lim       = (lim_psize < lim_mem) ? lim_psize : lim_mem;
      down_addr = rsp_view - WORD_W'(8);
      up_addr   = rsp_view + WORD_W'(8);
      q_addr    = ((q_item.kind == KIND_CALL) || (q_item.kind == KIND_PUSH)) ? down_addr
                                                                             : rsp_view;
      quad_fine = quad_ok(q_addr, lim);
   end

   // item decode at issue
   always_comb begin
      s2_ok_in        = 1'b0;
      s2_rsp_in       = rsp_view;
      s2_pc_in        = pc_view;
      s2_pc_mem_in    = 1'b0;
      s2_moved_in     = '0;
      s2_moved_mem_in = 1'b0;
      s2_wr_en_in     = 1'b0;
      s2_wr_idx_in    = q_item.reg_a;
      s2_wr_val_in    = q_item.operand;
      s2_wr_mem_in    = 1'b0;
      s2_off_in       = q_addr[2:0];
      mem_wr_quad     = 1'b0;
      mem_rd_quad     = 1'b0;
      mem_wr_byte     = 1'b0;
      wquad           = '0;
      unique case (q_item.kind)
         KIND_CALL: begin
            if (quad_fine) begin
               s2_ok_in    = 1'b1;
               s2_rsp_in   = down_addr;
               s2_pc_in    = q_item.operand;
               s2_moved_in = q_item.val_p;
               wquad       = q_item.val_p;
               mem_wr_quad = 1'b1;
            end
         end
         KIND_PUSH: begin
            if (quad_fine) begin
               s2_ok_in    = 1'b1;
               s2_rsp_in   = down_addr;
               s2_pc_in    = q_item.val_p;
               s2_moved_in = ra_view;
               wquad       = ra_view;
               mem_wr_quad = 1'b1;
            end
         end
         KIND_RET: begin
            if (quad_fine) begin
               s2_ok_in        = 1'b1;
               s2_rsp_in       = up_addr;
               s2_pc_mem_in    = 1'b1;
               s2_moved_mem_in = 1'b1;
               mem_rd_quad     = 1'b1;
            end
         end
         KIND_POP: begin
            if (quad_fine) begin
               s2_ok_in        = 1'b1;
               s2_rsp_in       = up_addr;
               s2_pc_in        = q_item.val_p;
               s2_wr_en_in     = 1'b1;
               s2_wr_mem_in    = 1'b1;
               s2_moved_mem_in = 1'b1;
               mem_rd_quad     = 1'b1;
            end
         end
         KIND_LOAD: begin
            s2_ok_in    = 1'b1;
            mem_wr_byte = 1'b1;
         end
         KIND_SETREG: begin
            s2_ok_in    = 1'b1;
            s2_wr_en_in = 1'b1;
         end
         default: begin
            s2_ok_in = 1'b0;
         end
      endcase
   end

   // bank addressing: unaligned quads wrap into the next row on low lanes
   always_comb begin
      ld_addr    = MEM_AW'(q_item.load_addr);
      q_row      = q_addr[MEM_AW-1:3];
      q_row_next = q_row + ROW_AW'(1);
      for (int b = 0; b < BANKS; b++) begin
         byte_idx = 3'(3'(b) - q_addr[2:0]);
         if (mem_wr_byte) begin
            bank_addr[b]  = ld_addr[MEM_AW-1:3];
            bank_wdata[b] = q_item.operand[7:0];
         end else begin
            bank_addr[b]  = (3'(b) < q_addr[2:0]) ? q_row_next : q_row;
            bank_wdata[b] = wquad[{byte_idx, 3'b000} +: 8];
         end
         bank_we[b] = mem_wr_quad || mem_wr_byte;
         bank_en[b] = issue && (mem_wr_quad || mem_rd_quad ||
                                (mem_wr_byte && (ld_addr[2:0] == 3'(b))));
      end
   end

   for (genvar g = 0; g < BANKS; g++) begin : g_bank
      y86so_bank u_bank (
         .clock (clock),
         .en    (bank_en[g]),
         .we    (bank_we[g]),
         .addr  (bank_addr[g]),
         .wdata (bank_wdata[g]),
         .rdata (bank_rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         pc_ff       <= '0;
      end else begin
         if (issue) begin
            s2_valid_ff <= 1'b1;
         end else if (commit) begin
            s2_valid_ff <= 1'b0;
         end
         if (commit) begin
            pc_ff <= final_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_ok_ff        <= s2_ok_in;
         s2_rsp_ff       <= s2_rsp_in;
         s2_pc_ff        <= s2_pc_in;
         s2_pc_mem_ff    <= s2_pc_mem_in;
         s2_moved_ff     <= s2_moved_in;
         s2_moved_mem_ff <= s2_moved_mem_in;
         s2_wr_en_ff     <= s2_wr_en_in;
         s2_wr_idx_ff    <= s2_wr_idx_in;
         s2_wr_val_ff    <= s2_wr_val_in;
         s2_wr_mem_ff    <= s2_wr_mem_in;
         s2_off_ff       <= s2_off_in;
      end
   end

   // register writeback; rsp takes the merged value, a reg_a write to rsp is already in it
   always_ff @(posedge clock) begin
      if (commit) begin
         rf_ff[RSP_INDEX] <= final_rsp;
         if (s2_wr_en_ff && (s2_wr_idx_ff != RSP_INDEX)) begin
            rf_ff[s2_wr_idx_ff] <= wb_val;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/y86_stack_op_unit.sv -----
// top level of the y86-64 call, ret, pushq and popq unit
`default_nettype none

// channel  dir  handshake            payload
// req      in   req_valid/req_ready  func icode reg_a val_c val_p load_addr load_value
// rsp      out  rsp_valid/rsp_ready  ok next_pc stack_ptr data_moved
// csr      in   psel/penable/pready  program_size at byte 0, 32-bit data
//
// sustains one item per cycle with rsp_ready high; beats go via queue, then result stage
// the rate is set by the eight byte-wide memory banks, each taking one access per cycle
// reset clears pc and sets program_size to 4096; no clearing pass, memory and
//   register file are undefined until written
// a two-beat queue lets the front keep taking beats while the result stage waits
// the result stage holds its beat while rsp_ready is low

`include "y86_stack_op_unit_defines.svh"

module y86_stack_op_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic [3:0]                    req_icode,
   input  wire logic [3:0]                    req_reg_a,
   input  wire logic [63:0]                   req_val_c,
   input  wire logic [63:0]                   req_val_p,
   input  wire logic [y86so_pkg::LOAD_AW-1:0] req_load_addr,
   input  wire logic [63:0]                   req_load_value,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ok,
   output logic [63:0]                        rsp_next_pc,
   output logic [63:0]                        rsp_stack_ptr,
   output logic [63:0]                        rsp_data_moved,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [y86so_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [y86so_pkg::CSR_DW-1:0]  pwdata,
   output logic [y86so_pkg::CSR_DW-1:0]       prdata,
   output logic                               pready
);
   import y86so_pkg::*;

   // program size register
   logic [PSIZE_W-1:0] psize_ff;
   logic               csr_wr;
   logic               csr_hit;

   // front to queue
   logic               q_ready;
   logic               q_push;
   item_type           q_in_item;

   // queue to back
   logic               q_valid;
   logic               q_pop;
   item_type           q_out_item;

   // ---------------------------------------------------------------------------
   // configuration: word index taken from paddr[2], byte lanes ignored
   // ---------------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_AW-1:2] == CSR_IDX_PSIZE);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign prdata  = csr_hit ? CSR_DW'(psize_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= PSIZE_RESET;
      end else if (csr_wr && csr_hit) begin
         psize_ff <= pwdata[PSIZE_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // front: decode the beat into an item kind, fail bad codes and far loads
   // ---------------------------------------------------------------------------
   y86so_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .func       (req_func),
      .icode      (req_icode),
      .reg_a      (req_reg_a),
      .val_c      (req_val_c),
      .val_p      (req_val_p),
      .load_addr  (req_load_addr),
      .load_value (req_load_value),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   // ---------------------------------------------------------------------------
   // decoupling queue
   // ---------------------------------------------------------------------------
   y86so_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (q_push),
      .in_item   (q_in_item),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_item  (q_out_item),
      .out_pop   (q_pop)
   );

   // ---------------------------------------------------------------------------
   // back: memory access at issue, state commit when the result beat leaves;
   // the item in the result stage is forwarded to the one being issued
   // ---------------------------------------------------------------------------
   y86so_back u_back (
      .clock          (clock),
      .reset          (reset),
      .program_size   (psize_ff),
      .q_valid        (q_valid),
      .q_item         (q_out_item),
      .q_pop          (q_pop),
      .res_valid      (rsp_valid),
      .res_ready      (rsp_ready),
      .res_ok         (rsp_ok),
      .res_next_pc    (rsp_next_pc),
      .res_stack_ptr  (rsp_stack_ptr),
      .res_data_moved (rsp_data_moved)
   );

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   `Y86SO_ASSERT_HOLDS(a_pop_needs_item, clock, reset, q_pop, q_valid,
      "back took an item from an empty queue")
   `Y86SO_ASSERT_HOLDS(a_no_issue_on_stall, clock, reset, rsp_valid && !rsp_ready, !q_pop,
      "item issued while the result stage was stalled")
   `Y86SO_ASSERT_HOLDS(a_fail_moves_nothing, clock, reset, rsp_valid && !rsp_ok,
      rsp_data_moved == '0, "failed result reports moved data")
   `Y86SO_ASSERT_NEXT(a_no_phantom_result, clock, reset, rsp_valid && rsp_ready && !q_valid,
      !rsp_valid, "result appeared with no queued item")

endmodule

`default_nettype wire
